>>> src/llr_pkg.sv
// ----------------------------------------------------------------------------
// llr_pkg
// Shared types, widths and codes of the lead/lag ratio fair price block.
// ----------------------------------------------------------------------------
package llr_pkg;

	localparam int WINDOW_MAX_DEF      = 256;
	localparam int RATIO_FRAC_BITS_DEF = 30;

	localparam int PRICE_W = 40;
	localparam int MID_W   = 41;
	localparam int RATIO_W = 32;
	localparam int FAIR_W  = 58;
	localparam int QUOTE_W = 59;
	localparam int ABS_W   = 48;
	localparam int FRAC_W  = 25;
	localparam int WLEN_W  = 9;
	localparam int CDATA_W = 48;
	localparam int CIDX_W  = 3;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd16;
	localparam logic [FRAC_W:0]   FRAC_ONE   = 26'd16777216;

	localparam logic [CIDX_W-1:0] CFG_USE_ABS  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_WLEN     = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_BID_ABS  = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_ASK_ABS  = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_BID_FRAC = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_ASK_FRAC = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RSTART,
		ST_RDIV,
		ST_PUSH,
		ST_MSTART,
		ST_MDIV,
		ST_MEAN,
		ST_CHECK,
		ST_FMUL_LO,
		ST_FMUL_HI,
		ST_FSAT,
		ST_ABS,
		ST_BMUL_LO,
		ST_BMUL_HI,
		ST_BSAT,
		ST_SMUL_LO,
		ST_SMUL_HI,
		ST_SSAT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_FAIR,
		MUL_BUY,
		MUL_SELL
	} mul_sel_t;

	typedef struct packed {
		logic     accept;
		logic     decode;
		logic     div_start;
		logic     div_mean;
		logic     push;
		logic     mean_load;
		logic     mul_lo;
		logic     mul_hi;
		mul_sel_t mul_sel;
		logic     fair_load;
		logic     buy_load;
		logic     sell_load;
		logic     abs_load;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic push_req;
		logic mean_upd;
		logic div_done;
		logic mean_nz;
		logic use_abs;
	} dp_stat_t;

endpackage

>>> src/llr_if.sv
// ----------------------------------------------------------------------------
// llr_if
// Request channels of the block: quote input, result output, register write.
// ----------------------------------------------------------------------------
interface llr_in_if;
	logic                        valid;
	logic                        ready;
	logic                        is_lead;
	logic [llr_pkg::PRICE_W-1:0] bid_price;
	logic [llr_pkg::PRICE_W-1:0] ask_price;

	modport source(output valid, is_lead, bid_price, ask_price, input ready);
	modport sink(input valid, is_lead, bid_price, ask_price, output ready);
endinterface

interface llr_out_if;
	logic                               valid;
	logic                               ready;
	logic                               fair_valid;
	logic [llr_pkg::RATIO_W-1:0]        fair_ratio;
	logic [llr_pkg::FAIR_W-1:0]         fair_price;
	logic signed [llr_pkg::QUOTE_W-1:0] fair_buy_price;
	logic [llr_pkg::QUOTE_W-1:0]        fair_sell_price;

	modport source(output valid, fair_valid, fair_ratio, fair_price, fair_buy_price,
		fair_sell_price, input ready);
	modport sink(input valid, fair_valid, fair_ratio, fair_price, fair_buy_price,
		fair_sell_price, output ready);
endinterface

interface llr_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [llr_pkg::CIDX_W-1:0]  index;
	logic [llr_pkg::CDATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> src/llr_ram.sv
// ----------------------------------------------------------------------------
// llr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/llr_div.sv
// ----------------------------------------------------------------------------
// llr_div
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// ----------------------------------------------------------------------------
module llr_div #(
	parameter int DEN_W = 41
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DEN_W-1:0]            rem_init,
	input  logic [llr_pkg::RATIO_W-1:0] low,
	input  logic [DEN_W-1:0]            den,
	output logic                        done,
	output logic [llr_pkg::RATIO_W-1:0] quot
);

	localparam int QW  = llr_pkg::RATIO_W;
	localparam int CNT_W = $clog2(QW);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QW-1:0]    q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, q_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den;
			q_q   <= low;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			q_q   <= {q_q[QW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(QW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

>>> src/llr_ctrl.sv
// ----------------------------------------------------------------------------
// llr_ctrl
// Sequencer: walks one quote through decode, divisions, multiplies, output.
// ----------------------------------------------------------------------------
module llr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                quote_valid,
	output logic                quote_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  llr_pkg::dp_stat_t   stat,
	output llr_pkg::ctrl_cmd_t  cmd
);

	llr_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign quote_ready  = state_q == llr_pkg::ST_IDLE;
	assign result_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			llr_pkg::ST_IDLE:    if (quote_valid) state_nxt = llr_pkg::ST_DECODE;
			llr_pkg::ST_DECODE:  state_nxt = stat.push_req ? llr_pkg::ST_RSTART : llr_pkg::ST_CHECK;
			llr_pkg::ST_RSTART:  state_nxt = llr_pkg::ST_RDIV;
			llr_pkg::ST_RDIV:    if (stat.div_done) state_nxt = llr_pkg::ST_PUSH;
			llr_pkg::ST_PUSH:    state_nxt = stat.mean_upd ? llr_pkg::ST_MSTART : llr_pkg::ST_CHECK;
			llr_pkg::ST_MSTART:  state_nxt = llr_pkg::ST_MDIV;
			llr_pkg::ST_MDIV:    if (stat.div_done) state_nxt = llr_pkg::ST_MEAN;
			llr_pkg::ST_MEAN:    state_nxt = llr_pkg::ST_CHECK;
			llr_pkg::ST_CHECK:   state_nxt = stat.mean_nz ? llr_pkg::ST_FMUL_LO : llr_pkg::ST_OUT;
			llr_pkg::ST_FMUL_LO: state_nxt = llr_pkg::ST_FMUL_HI;
			llr_pkg::ST_FMUL_HI: state_nxt = llr_pkg::ST_FSAT;
			llr_pkg::ST_FSAT:    state_nxt = stat.use_abs ? llr_pkg::ST_ABS : llr_pkg::ST_BMUL_LO;
			llr_pkg::ST_ABS:     state_nxt = llr_pkg::ST_OUT;
			llr_pkg::ST_BMUL_LO: state_nxt = llr_pkg::ST_BMUL_HI;
			llr_pkg::ST_BMUL_HI: state_nxt = llr_pkg::ST_BSAT;
			llr_pkg::ST_BSAT:    state_nxt = llr_pkg::ST_SMUL_LO;
			llr_pkg::ST_SMUL_LO: state_nxt = llr_pkg::ST_SMUL_HI;
			llr_pkg::ST_SMUL_HI: state_nxt = llr_pkg::ST_SSAT;
			llr_pkg::ST_SSAT:    state_nxt = llr_pkg::ST_OUT;
			llr_pkg::ST_OUT:     if (out_free) state_nxt = llr_pkg::ST_IDLE;
			default:             state_nxt = llr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = llr_pkg::MUL_FAIR;
		case (state_q)
			llr_pkg::ST_IDLE:    cmd.accept = quote_valid;
			llr_pkg::ST_DECODE:  cmd.decode = 1'b1;
			llr_pkg::ST_RSTART:  cmd.div_start = 1'b1;
			llr_pkg::ST_PUSH:    cmd.push = 1'b1;
			llr_pkg::ST_MSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_mean  = 1'b1;
			end
			llr_pkg::ST_MEAN:    cmd.mean_load = 1'b1;
			llr_pkg::ST_FMUL_LO: cmd.mul_lo = 1'b1;
			llr_pkg::ST_FMUL_HI: cmd.mul_hi = 1'b1;
			llr_pkg::ST_FSAT:    cmd.fair_load = 1'b1;
			llr_pkg::ST_ABS:     cmd.abs_load = 1'b1;
			llr_pkg::ST_BMUL_LO: begin
				cmd.mul_lo  = 1'b1;
				cmd.mul_sel = llr_pkg::MUL_BUY;
			end
			llr_pkg::ST_BMUL_HI: begin
				cmd.mul_hi  = 1'b1;
				cmd.mul_sel = llr_pkg::MUL_BUY;
			end
			llr_pkg::ST_BSAT:    cmd.buy_load = 1'b1;
			llr_pkg::ST_SMUL_LO: begin
				cmd.mul_lo  = 1'b1;
				cmd.mul_sel = llr_pkg::MUL_SELL;
			end
			llr_pkg::ST_SMUL_HI: begin
				cmd.mul_hi  = 1'b1;
				cmd.mul_sel = llr_pkg::MUL_SELL;
			end
			llr_pkg::ST_SSAT:    cmd.sell_load = 1'b1;
			llr_pkg::ST_OUT:     cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= llr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/llr_dp.sv
// ----------------------------------------------------------------------------
// llr_dp
// Datapath: mids, ratio ring and running sum, shared divider and multiplier,
// fair and quote prices, registers and the output register.
// ----------------------------------------------------------------------------
module llr_dp #(
	parameter int WINDOW_MAX      = llr_pkg::WINDOW_MAX_DEF,
	parameter int RATIO_FRAC_BITS = llr_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  llr_pkg::ctrl_cmd_t           cmd,
	output llr_pkg::dp_stat_t            stat,
	input  logic                         in_is_lead,
	input  logic [llr_pkg::PRICE_W-1:0]  in_bid,
	input  logic [llr_pkg::PRICE_W-1:0]  in_ask,
	input  logic                         cfg_we,
	input  logic [llr_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [llr_pkg::CDATA_W-1:0]  cfg_data,
	output logic                         out_fair_valid,
	output logic [llr_pkg::RATIO_W-1:0]  out_fair_ratio,
	output logic [llr_pkg::FAIR_W-1:0]   out_fair_price,
	output logic [llr_pkg::QUOTE_W-1:0]  out_buy_price,
	output logic [llr_pkg::QUOTE_W-1:0]  out_sell_price
);

	localparam int MID_W   = llr_pkg::MID_W;
	localparam int RW      = llr_pkg::RATIO_W;
	localparam int FW      = llr_pkg::FAIR_W;
	localparam int QTW     = llr_pkg::QUOTE_W;
	localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W   = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
	localparam int CMP_W   = LEN_W > llr_pkg::WLEN_W ? LEN_W : llr_pkg::WLEN_W;
	localparam int SUM_W   = RW + LEN_W;
	localparam int DW      = MID_W + RATIO_FRAC_BITS;
	localparam int HW      = DW - RW;
	localparam int RCMP_W  = HW > MID_W ? HW : MID_W;
	localparam int HALF    = 30;
	localparam int MA_W    = QTW;
	localparam int PLO_W   = HALF + RW;
	localparam int PHI_W   = MA_W - HALF + RW;
	localparam int PROD_W  = MA_W + RW;
	localparam int FAIR_SH = RATIO_FRAC_BITS - 15;
	localparam int FRAC_SH = 24;

	// registers
	logic                         use_abs_q;
	logic [llr_pkg::WLEN_W-1:0]   wlen_q;
	logic [llr_pkg::ABS_W-1:0]    bid_abs_q, ask_abs_q;
	logic [llr_pkg::FRAC_W-1:0]   bid_frac_q, ask_frac_q;

	// item and state
	logic                         lead_in_q;
	logic [llr_pkg::PRICE_W-1:0]  bid_q, ask_q;
	logic [MID_W-1:0]             lead_d_q, lag_d_q;
	logic                         await_q;
	logic [LEN_W-1:0]             fill_q;
	logic [IDX_W-1:0]             idx_q;
	logic [SUM_W-1:0]             sum_q;
	logic [RW-1:0]                mean_q;
	logic                         sat_q;
	logic [FW-1:0]                fair_q;
	logic [QTW-1:0]               buy_q, sell_q;
	logic [PLO_W-1:0]             plo_s1;
	logic [PHI_W-1:0]             phi_s1;

	// decode
	logic [MID_W-1:0]             mid_d;
	logic                         quote_ok, lead_upd, lag_upd;

	assign mid_d    = MID_W'(bid_q) + MID_W'(ask_q);
	assign quote_ok = bid_q < ask_q;
	assign lead_upd = quote_ok && lead_in_q && (mid_d != lead_d_q);
	assign lag_upd  = quote_ok && !lead_in_q && await_q && (mid_d != lag_d_q);

	// window length in use
	logic [CMP_W-1:0] wl_ext;
	logic [LEN_W-1:0] eff_len;

	always_comb begin
		wl_ext = CMP_W'(wlen_q);
		if (wl_ext == '0) begin
			eff_len = LEN_W'(1);
		end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
			eff_len = LEN_W'(WINDOW_MAX);
		end else begin
			eff_len = LEN_W'(wl_ext);
		end
	end

	// shared divider
	logic [DW-1:0]    rdiv_d;
	logic [HW-1:0]    rdiv_hi;
	logic [MID_W-1:0] div_rem, div_den;
	logic [RW-1:0]    div_low, div_quot;
	logic             div_done;

	assign rdiv_d  = DW'(lag_d_q) << RATIO_FRAC_BITS;
	assign rdiv_hi = rdiv_d[DW-1:RW];

	always_comb begin
		if (cmd.div_mean) begin
			div_rem = MID_W'(sum_q[SUM_W-1:RW]);
			div_den = MID_W'(eff_len);
			div_low = sum_q[RW-1:0];
		end else begin
			div_rem = MID_W'(rdiv_hi);
			div_den = lead_d_q;
			div_low = rdiv_d[RW-1:0];
		end
	end

	llr_div #(
		.DEN_W(MID_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.rem_init(div_rem),
		.low     (div_low),
		.den     (div_den),
		.done    (div_done),
		.quot    (div_quot)
	);

	// ratio ring
	logic [RW-1:0]    ratio, old_ratio;
	logic             full;
	logic [LEN_W-1:0] fill_inc, idx_inc;

	assign ratio    = sat_q ? '1 : div_quot;
	assign full     = fill_q == eff_len;
	assign fill_inc = fill_q + 1'b1;
	assign idx_inc  = LEN_W'(idx_q) + 1'b1;

	llr_ram #(
		.WIDTH(RW),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(idx_q),
		.wdata(ratio),
		.re   (cmd.decode),
		.raddr(idx_q),
		.rdata(old_ratio)
	);

	// shared multiplier, two partial products
	logic [MA_W-1:0]    mul_a;
	logic [RW-1:0]      mul_b;
	logic [llr_pkg::FRAC_W:0] bf_c, af_c;
	logic [PROD_W-1:0]  prod, fair_sh, frac_sh;
	logic [FW-1:0]      fair_val, buy_val;
	logic [QTW-1:0]     sell_val;

	assign bf_c = ({1'b0, bid_frac_q} > llr_pkg::FRAC_ONE) ? llr_pkg::FRAC_ONE : {1'b0, bid_frac_q};
	assign af_c = ({1'b0, ask_frac_q} > llr_pkg::FRAC_ONE) ? llr_pkg::FRAC_ONE : {1'b0, ask_frac_q};

	always_comb begin
		case (cmd.mul_sel)
			llr_pkg::MUL_BUY: begin
				mul_a = MA_W'(fair_q);
				mul_b = RW'(llr_pkg::FRAC_ONE - bf_c);
			end
			llr_pkg::MUL_SELL: begin
				mul_a = MA_W'(fair_q);
				mul_b = RW'(llr_pkg::FRAC_ONE + af_c);
			end
			default: begin
				mul_a = MA_W'(lead_d_q);
				mul_b = mean_q;
			end
		endcase
	end

	assign prod     = PROD_W'(plo_s1) + (PROD_W'(phi_s1) << HALF);
	assign fair_sh  = prod >> FAIR_SH;
	assign frac_sh  = prod >> FRAC_SH;
	assign fair_val = (|fair_sh[PROD_W-1:FW]) ? '1 : fair_sh[FW-1:0];
	assign buy_val  = (|frac_sh[PROD_W-1:FW]) ? '1 : frac_sh[FW-1:0];
	assign sell_val = (|frac_sh[PROD_W-1:QTW]) ? '1 : frac_sh[QTW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lead_in_q <= in_is_lead;
			bid_q     <= in_bid;
			ask_q     <= in_ask;
		end
		if (cmd.mul_lo) begin
			plo_s1 <= PLO_W'(mul_a[HALF-1:0]) * PLO_W'(mul_b);
		end
		if (cmd.mul_hi) begin
			phi_s1 <= PHI_W'(mul_a[MA_W-1:HALF]) * PHI_W'(mul_b);
		end
		// saturation is known once the ratio division starts
		if (cmd.div_start && !cmd.div_mean) begin
			sat_q <= RCMP_W'(rdiv_hi) >= RCMP_W'(lead_d_q);
		end
		if (cmd.out_load) begin
			out_fair_valid <= mean_q != '0;
			out_fair_ratio <= mean_q;
			out_fair_price <= fair_q;
			out_buy_price  <= buy_q;
			out_sell_price <= sell_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_abs_q  <= 1'b0;
			wlen_q     <= llr_pkg::WLEN_RESET;
			bid_abs_q  <= '0;
			ask_abs_q  <= '0;
			bid_frac_q <= '0;
			ask_frac_q <= '0;
			lead_d_q   <= '0;
			lag_d_q    <= '0;
			await_q    <= 1'b0;
			fill_q     <= '0;
			idx_q      <= '0;
			sum_q      <= '0;
			mean_q     <= '0;
			fair_q     <= '0;
			buy_q      <= '0;
			sell_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					llr_pkg::CFG_USE_ABS:  use_abs_q <= cfg_data[0];
					llr_pkg::CFG_WLEN: begin
						wlen_q <= cfg_data[llr_pkg::WLEN_W-1:0];
						// refill the window from scratch
						fill_q <= '0;
						idx_q  <= '0;
						sum_q  <= '0;
					end
					llr_pkg::CFG_BID_ABS:  bid_abs_q  <= cfg_data[llr_pkg::ABS_W-1:0];
					llr_pkg::CFG_ASK_ABS:  ask_abs_q  <= cfg_data[llr_pkg::ABS_W-1:0];
					llr_pkg::CFG_BID_FRAC: bid_frac_q <= cfg_data[llr_pkg::FRAC_W-1:0];
					llr_pkg::CFG_ASK_FRAC: ask_frac_q <= cfg_data[llr_pkg::FRAC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.decode) begin
				if (lead_upd) begin
					lead_d_q <= mid_d;
					await_q  <= 1'b1;
				end
				if (lag_upd) begin
					lag_d_q <= mid_d;
					await_q <= 1'b0;
				end
			end
			if (cmd.push) begin
				if (!full) begin
					fill_q <= fill_inc;
					sum_q  <= sum_q + SUM_W'(ratio);
					idx_q  <= (fill_inc == eff_len) ? '0 : IDX_W'(idx_inc);
				end else begin
					sum_q <= sum_q - SUM_W'(old_ratio) + SUM_W'(ratio);
					idx_q <= (idx_inc >= eff_len) ? '0 : IDX_W'(idx_inc);
				end
			end
			if (cmd.mean_load) begin
				mean_q <= div_quot;
			end
			if (cmd.fair_load) begin
				fair_q <= fair_val;
			end
			if (cmd.buy_load) begin
				buy_q <= QTW'(buy_val);
			end
			if (cmd.sell_load) begin
				sell_q <= sell_val;
			end
			if (cmd.abs_load) begin
				buy_q  <= QTW'(fair_q) - QTW'(bid_abs_q);
				sell_q <= QTW'(fair_q) + QTW'(ask_abs_q);
			end
		end
	end

	assign stat.push_req = lag_upd;
	assign stat.mean_upd = full || (fill_inc == eff_len);
	assign stat.div_done = div_done;
	assign stat.mean_nz  = mean_q != '0;
	assign stat.use_abs  = use_abs_q;

endmodule

>>> src/lead_lag_ratio_fair_price_top.sv
// Lead/lag ratio fair price. Quote ticks enter one at a time on the quote
// channel and each gives exactly one result on the result channel; a finished
// result waits in an output register while the next quote is taken. While a
// fair ratio exists, a tick computes the fair price and then its quotes from
// absolute or fractional offsets. A tick that forms a new lag/lead ratio
// first runs the ratio division and, once the window is full, the mean
// division. A tick is held at its output step while a previous result still
// waits in the output register. Both divisions share one divider that
// retires one quotient bit per cycle. Register writes are taken at any time
// on the cfg channel and must only be issued while idle.
// ----------------------------------------------------------------------------
// lead_lag_ratio_fair_price_top
// Top level: controller, datapath, channel hookup.
// ----------------------------------------------------------------------------
module lead_lag_ratio_fair_price_top #(
	parameter int WINDOW_MAX      = llr_pkg::WINDOW_MAX_DEF,
	parameter int RATIO_FRAC_BITS = llr_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	llr_in_if.sink     quote,
	llr_out_if.source  result,
	llr_cfg_if.sink    cfg
);

	llr_pkg::ctrl_cmd_t          cmd;
	llr_pkg::dp_stat_t           stat;
	logic [llr_pkg::QUOTE_W-1:0] buy_price;

	assign cfg.ready = 1'b1;

	llr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.quote_valid (quote.valid),
		.quote_ready (quote.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	llr_dp #(
		.WINDOW_MAX     (WINDOW_MAX),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_is_lead    (quote.is_lead),
		.in_bid        (quote.bid_price),
		.in_ask        (quote.ask_price),
		.cfg_we        (cfg.valid && cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_fair_valid(result.fair_valid),
		.out_fair_ratio(result.fair_ratio),
		.out_fair_price(result.fair_price),
		.out_buy_price (buy_price),
		.out_sell_price(result.fair_sell_price)
	);

	assign result.fair_buy_price = $signed(buy_price);

	// one quote in flight: no second accept right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		quote.valid && quote.ready |=> !quote.ready)
		else $error("quote accepted while busy");

	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.fair_valid == (result.fair_ratio != '0)))
		else $error("fair_valid disagrees with fair_ratio");

	// a result never appears in the cycle right after an accept
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		quote.valid && quote.ready && !result.valid |=> !result.valid)
		else $error("result without processing");

endmodule
